/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file of the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define PRAM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication, disabled while reset is held
`define PRAM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

/* rtl/core/pram_pkg.sv */
// shared types and constants of the packet rate anomaly monitor
`timescale 1ns / 1ps

package pram_pkg;

    // default ring depth of the history
    localparam int unsigned HISTORY_DEPTH_DEF = 64;

    // input kinds carried on s_tuser
    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // register map
    localparam logic [1:0] ADDR_BIN_TICKS   = 2'd0;
    localparam logic [15:0] BIN_TICKS_RESET = 16'd100;

    // rate window constants
    localparam int unsigned RATE_CLAMP      = 255;
    localparam int unsigned RECENT_BINS     = 10;
    localparam int unsigned RSSI_BINS       = 5;
    localparam int unsigned BASE_MIN_BINS   = 15;
    localparam int unsigned STATUS_MIN_BINS = 25;
    localparam int unsigned BASE_MIN_RATE   = 4;
    localparam int unsigned LOW_FACTOR      = 3;
    localparam int unsigned HIGH_MARGIN     = 8;
    localparam int unsigned RATE_MAX        = RECENT_BINS * RATE_CLAMP;

    // shared divider: one quotient bit per cycle
    localparam int unsigned DIV_W   = 24;
    localparam int unsigned DEN_W   = 16;

    // result status codes
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_NORMAL = 2'd1,
        ST_LOW    = 2'd2,
        ST_HIGH   = 2'd3
    } status_t;

    // result word, first field in the highest bits
    typedef struct packed {
        status_t     status;
        logic [6:0]  bins_filled;
        logic [7:0]  recent_rssi;
        logic [11:0] baseline_rate;
        logic [11:0] recent_rate;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned TDATA_W  = 48;

endpackage

/* rtl/core/packet_rate_anomaly_monitor.sv */
// packet rate anomaly monitor: bin counters, history ring memory and rate report
//
//   channel  | direction | transfer content
//   s_*      | in        | tuser opcode, tdata rssi
//   m_*      | out       | tdata recent/baseline rate, recent rssi, bins filled, status
//   apb      | in/out    | bin_ticks register at address 0
//
// one item at a time: a packet, an unused opcode or a tick that keeps the bin open runs a
// walk of up to ten history reads and then the baseline division; a tick that closes a bin
// first runs the bin mean division and the ring write; the 24-step shared divider serves both,
// and the baseline division is skipped while at most fifteen bins are filled.
// aresetn is synchronous; history is not swept, a fill count masks stale entries.
// input is taken again while a finished result still waits in the output register;
// a stalled m_tready only holds the block in its last cycle.
`timescale 1ns / 1ps

module packet_rate_anomaly_monitor #(
    parameter int unsigned HISTORY_DEPTH = pram_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rssi
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [11:0] recent_rate, [23:12] baseline_rate,
                                   // [31:24] recent_rssi, [38:32] bins_filled,
                                   // [40:39] status, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pram_pkg::*;

    localparam int unsigned PW = $clog2(HISTORY_DEPTH);
    localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned TW = $clog2(RATE_CLAMP * HISTORY_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_WRITE = 6'b000100,
        S_WALK  = 6'b001000,
        S_BDIV  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]   bin_ticks_reg, bin_ticks_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic          full_reg, full_next;
    logic [15:0]   pkt_cnt_reg, pkt_cnt_next;
    logic [15:0]   rssi_cnt_reg, rssi_cnt_next;
    logic [23:0]   rssi_sum_reg, rssi_sum_next;
    logic [15:0]   tick_reg, tick_next;
    logic [TW-1:0] total_reg, total_next;

    logic [DIV_W-1:0] div_q_reg, div_q_next;
    logic [DEN_W-1:0] div_rem_reg, div_rem_next;
    logic [DEN_W-1:0] div_den_reg, div_den_next;
    logic [4:0]       div_cnt_reg, div_cnt_next;

    logic [3:0]  age_reg, age_next;
    logic        rd_valid_reg, rd_valid_next;
    logic [3:0]  rd_age_reg, rd_age_next;
    logic [11:0] recent_reg, recent_next;
    logic [7:0]  rr_reg, rr_next;
    logic        rr_found_reg, rr_found_next;
    logic [11:0] base_reg, base_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // history ring: {rate, mean rssi} per bin
    logic [15:0]   hist_mem [HISTORY_DEPTH];
    logic [15:0]   mem_rd_reg;
    logic          mem_we;
    logic [15:0]   mem_wdata;
    logic [PW-1:0] rd_addr;

    logic        cfg_we;
    logic        s_accept;
    logic [15:0] bin_len;
    logic [16:0] tick_inc;

    logic [DEN_W:0]   rem_sh;
    logic             div_ge;
    logic [DEN_W-1:0] rem_step;
    logic [DIV_W-1:0] q_step;
    logic             div_last;

    logic [FW-1:0] filled;
    logic [3:0]    n_walk;
    logic [PW:0]   slot_sum;
    logic [PW-1:0] slot_idx;
    logic [7:0]    rd_rate;
    logic [7:0]    rd_rssi;
    logic [7:0]    cnt8;
    logic [7:0]    q8;
    logic [7:0]    avg8;
    logic [23:0]   sum_mag;
    logic [TW-1:0] base_sum;
    logic [TW+3:0] base_x10;
    logic [13:0]   recent_x3;
    logic [13:0]   base_x2p8;
    status_t       status;
    result_t       res;
    logic          walk_init;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_BIN_TICKS) ? {16'd0, bin_ticks_reg} : 32'd0;
    assign cfg_we   = psel && penable && pwrite && pready && (paddr == ADDR_BIN_TICKS);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // bin length and tick increment
    assign bin_len  = (bin_ticks_reg == 16'd0) ? 16'd1 : bin_ticks_reg;
    assign tick_inc = {1'b0, tick_reg} + 17'd1;

    // one restoring division step
    assign rem_sh   = {div_rem_reg, div_q_reg[DIV_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign rem_step = div_ge ? DEN_W'(rem_sh - {1'b0, div_den_reg}) : rem_sh[DEN_W-1:0];
    assign q_step   = {div_q_reg[DIV_W-2:0], div_ge};
    assign div_last = (div_cnt_reg == 5'(DIV_W - 1));

    // fill count and walk address
    assign filled   = full_reg ? FW'(HISTORY_DEPTH) : FW'(wp_reg);
    assign n_walk   = (filled < FW'(RECENT_BINS)) ? 4'(filled) : 4'(RECENT_BINS);
    assign slot_sum = {1'b0, wp_reg} + (PW+1)'(HISTORY_DEPTH - 1) - (PW+1)'(age_reg);
    assign slot_idx = (slot_sum >= (PW+1)'(HISTORY_DEPTH))
                    ? PW'(slot_sum - (PW+1)'(HISTORY_DEPTH)) : slot_sum[PW-1:0];
    assign rd_addr  = (state_reg == S_WALK) ? slot_idx : wp_reg;
    assign rd_rate  = mem_rd_reg[15:8];
    assign rd_rssi  = mem_rd_reg[7:0];

    // closing bin: clamped count and mean rounded toward zero
    assign cnt8      = (pkt_cnt_reg > 16'(RATE_CLAMP)) ? 8'(RATE_CLAMP) : pkt_cnt_reg[7:0];
    assign sum_mag   = rssi_sum_reg[23] ? (~rssi_sum_reg + 24'd1) : rssi_sum_reg;
    assign q8        = div_q_reg[7:0];
    assign avg8      = (rssi_cnt_reg == 16'd0) ? 8'd0
                     : (rssi_sum_reg[23] ? (~q8 + 8'd1) : q8);
    assign mem_wdata = {cnt8, avg8};

    // baseline dividend: older-bin sum times ten
    assign base_sum = total_reg - TW'(recent_reg);
    assign base_x10 = {1'b0, base_sum, 3'b000} + {3'b000, base_sum, 1'b0};

    // status compare
    assign recent_x3 = {2'b00, recent_reg} + {1'b0, recent_reg, 1'b0};
    assign base_x2p8 = {1'b0, base_reg, 1'b0} + 14'(HIGH_MARGIN);

    always_comb begin
        if (filled < FW'(STATUS_MIN_BINS) || base_reg < 12'(BASE_MIN_RATE)) begin
            status = ST_IDLE;
        end else if (recent_x3 < {2'b00, base_reg}) begin
            status = ST_LOW;
        end else if ({2'b00, recent_reg} > base_x2p8) begin
            status = ST_HIGH;
        end else begin
            status = ST_NORMAL;
        end
    end

    assign res.status        = status;
    assign res.bins_filled   = 7'(filled);
    assign res.recent_rssi   = rr_reg;
    assign res.baseline_rate = base_reg;
    assign res.recent_rate   = recent_reg;

    // sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        bin_ticks_next = cfg_we ? pwdata[15:0] : bin_ticks_reg;
        wp_next        = wp_reg;
        full_next      = full_reg;
        pkt_cnt_next   = pkt_cnt_reg;
        rssi_cnt_next  = rssi_cnt_reg;
        rssi_sum_next  = rssi_sum_reg;
        tick_next      = tick_reg;
        total_next     = total_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        age_next       = age_reg;
        rd_valid_next  = rd_valid_reg;
        rd_age_next    = rd_age_reg;
        recent_next    = recent_reg;
        rr_next        = rr_reg;
        rr_found_next  = rr_found_reg;
        base_next      = base_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        walk_init      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    walk_init  = 1'b1;
                    state_next = S_WALK;
                    case (s_tuser)
                        OP_PACKET: begin
                            if (pkt_cnt_reg != 16'hFFFF) begin
                                pkt_cnt_next = pkt_cnt_reg + 16'd1;
                            end
                            if (rssi_cnt_reg != 16'hFFFF) begin
                                rssi_cnt_next = rssi_cnt_reg + 16'd1;
                                rssi_sum_next = rssi_sum_reg
                                              + {{16{s_tdata[7]}}, s_tdata};
                            end
                        end
                        OP_TICK: begin
                            if (tick_inc >= {1'b0, bin_len}) begin
                                tick_next    = 16'd0;
                                div_q_next   = sum_mag;
                                div_rem_next = '0;
                                div_den_next = rssi_cnt_reg;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end else begin
                                tick_next = tick_inc[15:0];
                            end
                        end
                        OP_CLEAR: begin
                            wp_next       = '0;
                            full_next     = 1'b0;
                            pkt_cnt_next  = '0;
                            rssi_cnt_next = '0;
                            rssi_sum_next = '0;
                            tick_next     = '0;
                            total_next    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                div_q_next   = q_step;
                div_rem_next = rem_step;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_last) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                // mem_rd_reg holds the entry about to be overwritten
                mem_we        = 1'b1;
                total_next    = total_reg - (full_reg ? TW'(rd_rate) : TW'(0)) + TW'(cnt8);
                wp_next       = (wp_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
                full_next     = full_reg || (wp_reg == PW'(HISTORY_DEPTH - 1));
                pkt_cnt_next  = '0;
                rssi_cnt_next = '0;
                rssi_sum_next = '0;
                walk_init     = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK: begin
                // issue one read per cycle, newest bin first
                if (age_reg < n_walk) begin
                    rd_valid_next = 1'b1;
                    rd_age_next   = age_reg;
                    age_next      = age_reg + 4'd1;
                end else begin
                    rd_valid_next = 1'b0;
                end
                if (rd_valid_reg) begin
                    recent_next = recent_reg + {4'd0, rd_rate};
                    if (rd_age_reg < 4'(RSSI_BINS) && !rr_found_reg && rd_rssi != 8'd0) begin
                        rr_next       = rd_rssi;
                        rr_found_next = 1'b1;
                    end
                end
                if (age_reg >= n_walk && !rd_valid_reg) begin
                    if (filled > FW'(BASE_MIN_BINS)) begin
                        div_q_next   = DIV_W'(base_x10);
                        div_rem_next = '0;
                        div_den_next = DEN_W'(filled - FW'(RECENT_BINS));
                        div_cnt_next = '0;
                        state_next   = S_BDIV;
                    end else begin
                        base_next  = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_BDIV: begin
                div_q_next   = q_step;
                div_rem_next = rem_step;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_last) begin
                    base_next  = q_step[11:0];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(TDATA_W - RESULT_W)'(0), res};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // fresh walk accumulators
        if (walk_init) begin
            age_next      = '0;
            rd_valid_next = 1'b0;
            recent_next   = '0;
            rr_next       = '0;
            rr_found_next = 1'b0;
        end
    end

    // history memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wp_reg] <= mem_wdata;
        end
        mem_rd_reg <= hist_mem[rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bin_ticks_reg <= BIN_TICKS_RESET;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            pkt_cnt_reg   <= '0;
            rssi_cnt_reg  <= '0;
            rssi_sum_reg  <= '0;
            tick_reg      <= '0;
            total_reg     <= '0;
            div_cnt_reg   <= '0;
            age_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rr_found_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bin_ticks_reg <= bin_ticks_next;
            wp_reg        <= wp_next;
            full_reg      <= full_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            rssi_cnt_reg  <= rssi_cnt_next;
            rssi_sum_reg  <= rssi_sum_next;
            tick_reg      <= tick_next;
            total_reg     <= total_next;
            div_cnt_reg   <= div_cnt_next;
            age_reg       <= age_next;
            rd_valid_reg  <= rd_valid_next;
            rr_found_reg  <= rr_found_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        rd_age_reg  <= rd_age_next;
        recent_reg  <= recent_next;
        rr_reg      <= rr_next;
        base_reg    <= base_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

/* rtl/core/pram_checker.sv */
// port-level checks of the packet rate anomaly monitor and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pram_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import pram_pkg::*;

    result_t res;

    assign res = m_tdata[RESULT_W-1:0];

    // one item in flight: ready drops right after a transfer
    `PRAM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a stalled result holds
    `PRAM_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // a live status needs a usable baseline
    `PRAM_ASSERT_IMP(a_status_baseline, aclk, aresetn, m_tvalid && res.status != ST_IDLE,
        res.baseline_rate >= 12'(BASE_MIN_RATE))

    // rates stay within ten clamped bins
    `PRAM_ASSERT_IMP(a_rate_range, aclk, aresetn, m_tvalid,
        res.recent_rate <= 12'(RATE_MAX) && res.baseline_rate <= 12'(RATE_MAX))

endmodule

bind packet_rate_anomaly_monitor pram_checker u_pram_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/rate_report_checker.sv */
// checker for the packet rate anomaly monitor: predicts every rate report and compares it
`timescale 1ns / 1ps

module rate_report_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rssi
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [11:0] recent_rate, [23:12] baseline_rate,
                                   // [31:24] recent_rssi, [38:32] bins_filled,
                                   // [40:39] status, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    import pram_pkg::*;

    localparam int unsigned DEPTH   = HISTORY_DEPTH_DEF;
    localparam int unsigned CNT_MAX = 65535;

    // predicted state of the monitor
    logic [15:0]       bin_len;
    logic [7:0]        rate_hist [DEPTH];
    logic signed [7:0] rssi_hist [DEPTH];
    int unsigned       wr_ptr;
    bit                wrapped;
    int unsigned       pkt_count;
    int unsigned       rssi_count;
    int unsigned       tick_count;
    int                rssi_sum;

    result_t           expected_reports [$];
    int                mismatches;
    int                reports_seen;

    assign fail_count = mismatches;

    // ring index of the entry written age bins before the newest
    function automatic int unsigned slot_of(int unsigned age);
        return (wr_ptr + DEPTH - 1 - age) % DEPTH;
    endfunction

    function automatic void clear_history();
        foreach (rate_hist[i]) begin
            rate_hist[i] = '0;
            rssi_hist[i] = '0;
        end
        wr_ptr     = 0;
        wrapped    = 1'b0;
        pkt_count  = 0;
        rssi_sum   = 0;
        rssi_count = 0;
        tick_count = 0;
    endfunction

    // push the clamped count and truncated mean of the open bin into the ring
    function automatic void close_bin();
        int mean;
        mean = 0;
        if (rssi_count != 0)
            mean = rssi_sum / int'(rssi_count);
        rate_hist[wr_ptr] = (pkt_count > RATE_CLAMP) ? 8'(RATE_CLAMP) : 8'(pkt_count);
        rssi_hist[wr_ptr] = 8'(mean);
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (wr_ptr == 0)
            wrapped = 1'b1;
        pkt_count  = 0;
        rssi_sum   = 0;
        rssi_count = 0;
    endfunction

    // apply one event and work out the report it causes
    function automatic result_t apply_event(logic [1:0] op, logic signed [7:0] rssi);
        int unsigned recent;
        int unsigned filled;
        int unsigned older_sum;
        int unsigned older_n;
        int unsigned base;
        int unsigned len;
        int          last_rssi;
        result_t     r;

        case (op)
            OP_PACKET: begin
                if (pkt_count < CNT_MAX)
                    pkt_count++;
                // the sum freezes together with its count
                if (rssi_count < CNT_MAX) begin
                    rssi_count++;
                    rssi_sum += rssi;
                end
            end
            OP_TICK: begin
                len = (bin_len == 0) ? 1 : bin_len;
                tick_count++;
                if (tick_count >= len) begin
                    tick_count = 0;
                    close_bin();
                end
            end
            OP_CLEAR: clear_history();
            default: ;
        endcase

        recent = 0;
        for (int unsigned i = 0; i < RECENT_BINS; i++)
            recent += rate_hist[slot_of(i)];

        filled = wrapped ? DEPTH : wr_ptr;

        // baseline over the older bins, scaled to the recent window
        base = 0;
        if (filled > BASE_MIN_BINS) begin
            older_sum = 0;
            older_n   = 0;
            for (int unsigned i = RECENT_BINS; i < filled; i++) begin
                older_sum += rate_hist[slot_of(i)];
                older_n++;
            end
            if (older_n != 0)
                base = older_sum * RECENT_BINS / older_n;
        end

        // walk from oldest to newest so the newest nonzero mean wins
        last_rssi = 0;
        for (int i = RSSI_BINS - 1; i >= 0; i--)
            if (rssi_hist[slot_of(i)] != 0)
                last_rssi = rssi_hist[slot_of(i)];

        if (filled < STATUS_MIN_BINS || base < BASE_MIN_RATE)
            r.status = ST_IDLE;
        else if (recent * LOW_FACTOR < base)
            r.status = ST_LOW;
        else if (recent > base * 2 + HIGH_MARGIN)
            r.status = ST_HIGH;
        else
            r.status = ST_NORMAL;

        r.recent_rate   = 12'(recent);
        r.baseline_rate = 12'(base);
        r.recent_rssi   = 8'(last_rssi);
        r.bins_filled   = 7'(filled);
        return r;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: report %0d %s: got %0d, want %0d",
                 $time, reports_seen, field, got, want);
        mismatches++;
    endtask

    // watch config writes, input transfers and result transfers
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            bin_len = BIN_TICKS_RESET;
            clear_history();
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_BIN_TICKS)
                bin_len = pwdata[15:0];

            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with none pending", int'(got), 0);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.recent_rate != want.recent_rate)
                        report_mismatch("recent_rate", got.recent_rate, want.recent_rate);
                    if (got.baseline_rate != want.baseline_rate)
                        report_mismatch("baseline_rate", got.baseline_rate,
                                        want.baseline_rate);
                    if (got.recent_rssi != want.recent_rssi)
                        report_mismatch("recent_rssi", $signed(got.recent_rssi),
                                        $signed(want.recent_rssi));
                    if (got.bins_filled != want.bins_filled)
                        report_mismatch("bins_filled", got.bins_filled, want.bins_filled);
                    if (got.status != want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (m_tdata[TDATA_W-1:RESULT_W] != '0)
                        report_mismatch("padding", int'(m_tdata[TDATA_W-1:RESULT_W]), 0);
                end
                reports_seen++;
            end

            if (s_tvalid && s_tready)
                expected_reports.push_back(apply_event(s_tuser, s_tdata));
        end
        pending <= expected_reports.size();
    end

endmodule

/* tb/sv/tb.sv */
// top of the packet rate anomaly monitor testbench: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module tb;
    import pram_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         ITEM_TARGET  = 1650;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         BURST_LEN    = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    bit          steady;
    int          sent;

    packet_rate_anomaly_monitor dut (.*);

    rate_report_checker report_check (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side: random stalls except in the steady phase
    always @(negedge aclk)
        m_tready = steady || ($urandom_range(99) >= 8);

    // hard stop
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // one event transfer, with random idle cycles ahead of it
    task automatic send_event(logic [1:0] op, logic [7:0] rssi);
        while (!steady && $urandom_range(99) < 8) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = rssi;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
    endtask

    // hold the input until every pending report has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_bin_ticks(logic [15:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_BIN_TICKS;
        pwdata  = 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        int          phase;
        int          nbins;
        int          level;
        int          k;
        int          ticks_per_bin;
        logic [15:0] len;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_PACKET;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = ADDR_BIN_TICKS;
        pwdata   = '0;
        steady   = 1'b0;
        sent     = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset bin length: rssi extremes and the unused opcode, nothing closes
        send_event(OP_PACKET, 8'h7f);
        send_event(OP_PACKET, 8'h80);
        send_event(OP_UNUSED, 8'h55);
        send_event(OP_TICK, 8'h00);
        wait_drained();

        // zero bin length acts as one tick per bin
        write_bin_ticks(16'd0);
        send_event(OP_TICK, 8'h00);
        // negative mean truncates toward zero
        send_event(OP_PACKET, 8'hff);
        send_event(OP_PACKET, 8'hfe);
        send_event(OP_TICK, 8'h00);
        // zero mean is skipped by the rssi lookup
        send_event(OP_PACKET, 8'h05);
        send_event(OP_PACKET, 8'hfb);
        send_event(OP_TICK, 8'hff);
        send_event(OP_PACKET, 8'h7f);
        send_event(OP_TICK, 8'h00);
        send_event(OP_PACKET, 8'h80);
        send_event(OP_PACKET, 8'h80);
        send_event(OP_TICK, 8'h00);
        send_event(OP_UNUSED, 8'haa);
        send_event(OP_CLEAR, 8'h00);
        send_event(OP_PACKET, 8'h00);
        send_event(OP_TICK, 8'h00);
        wait_drained();

        // random phases of bins whose packet density drifts between regimes
        for (phase = 0; sent < ITEM_TARGET; phase++) begin
            if (phase == 3)
                len = 16'hffff;
            else if ($urandom_range(9) == 0)
                len = 16'($urandom_range(2, 5));
            else
                len = 16'($urandom_range(0, 2));
            write_bin_ticks(len);
            steady = (phase == 2);
            if (phase != 0 && $urandom_range(3) == 0)
                send_event(OP_CLEAR, 8'($urandom_range(255)));

            if (len == 16'hffff) begin
                // longest bins: ticks accumulate without closing
                repeat (12) send_event(2'($urandom_range(1)), 8'($urandom_range(255)));
            end else begin
                ticks_per_bin = (len == 0) ? 1 : len;
                nbins = $urandom_range(20, 70);
                level = $urandom_range(0, 5);
                for (int b = 0; b < nbins && sent < ITEM_TARGET; b++) begin
                    if ($urandom_range(9) == 0)
                        level = $urandom_range(0, 6);
                    for (int t = 0; t < ticks_per_bin; t++) begin
                        k = (level == 0) ? 0 : $urandom_range(0, 2 * level);
                        // one crowded bin to hit the rate clamp
                        if (phase == 1 && b == 4 && t == 0)
                            k = BURST_LEN;
                        repeat (k) send_event(OP_PACKET, 8'($urandom_range(255)));
                        if ($urandom_range(49) == 0)
                            send_event(OP_UNUSED, 8'($urandom_range(255)));
                        if ($urandom_range(499) == 0)
                            send_event(OP_CLEAR, 8'($urandom_range(255)));
                        send_event(OP_TICK, 8'($urandom_range(255)));
                    end
                end
            end
            wait_drained();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/pram_pkg.sv
rtl/core/packet_rate_anomaly_monitor.sv
rtl/core/pram_checker.sv
tb/sv/rate_report_checker.sv
tb/sv/tb.sv
